FILE: rtl/lps_pkg.sv
// shared types, codes and defaults for the led pattern sequencer
package lps_pkg;

    localparam int LED_COUNT_DEF     = 32;
    localparam int PALETTE_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;

    // input item kinds
    localparam logic [1:0] KIND_REFRESH = 2'd0;
    localparam logic [1:0] KIND_MODE    = 2'd1;
    localparam logic [1:0] KIND_LOAD    = 2'd2;

    // effect modes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_CHASE_A = 2'd1;
    localparam logic [1:0] MODE_CHASE_B = 2'd2;
    localparam logic [1:0] MODE_FADE    = 2'd3;

    // queued command opcodes
    localparam logic [1:0] OP_REFRESH = 2'd0;
    localparam logic [1:0] OP_MODE    = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] mode_value;
        logic       palette_select;
        logic [3:0] entry_index;
        logic [7:0] load_red;
        logic [7:0] load_green;
        logic [7:0] load_blue;
    } in_item_t;

    typedef struct packed {
        logic [4:0] led_index;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [1:0] active_mode;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  mode_value;
        logic        palette_select;
        logic [3:0]  entry_index;
        logic [23:0] color;
    } cmd_t;

endpackage

FILE: rtl/lps_ram.sv
// generic single write port ram with registered read
module lps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lps_front.sv
// front end: takes input beats, drops no-op items and turns the rest into commands
module lps_front #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic             in_valid,
    output logic             in_ready,
    input  lps_pkg::in_item_t in_data,
    input  logic             q_full,
    output logic             q_push,
    output lps_pkg::cmd_t    q_cmd
);

    import lps_pkg::*;

    logic keep;

    always_comb
    begin
        keep       = 1'b0;
        q_cmd.op   = OP_REFRESH;
        case (in_data.kind)
            KIND_REFRESH:
            begin
                keep     = 1'b1;
                q_cmd.op = OP_REFRESH;
            end
            KIND_MODE:
            begin
                keep     = 1'b1;
                q_cmd.op = OP_MODE;
            end
            KIND_LOAD:
            begin
                // loads past the palette end are dropped here
                keep     = (int'(in_data.entry_index) < PALETTE_DEPTH);
                q_cmd.op = OP_LOAD;
            end
            default:
            begin
                keep     = 1'b0;
                q_cmd.op = OP_REFRESH;
            end
        endcase
        q_cmd.mode_value     = in_data.mode_value;
        q_cmd.palette_select = in_data.palette_select;
        q_cmd.entry_index    = in_data.entry_index;
        q_cmd.color          = {in_data.load_red, in_data.load_green, in_data.load_blue};
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: rtl/lps_queue.sv
// short command fifo between front end and back end
module lps_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lps_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output lps_pkg::cmd_t dout,
    output logic          empty
);

    import lps_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = NW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = NW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = entries_reg[rd_ptr_reg];
    assign full  = (int'(count_reg) == DEPTH);
    assign empty = (count_reg == '0);

endmodule

FILE: rtl/lps_back.sv
// back end: effect state, palette memory and the per-led beat generator
module lps_back #(
    parameter int LED_COUNT     = 32,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               q_empty,
    output logic               q_pop,
    input  lps_pkg::cmd_t      q_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output lps_pkg::out_item_t out_data
);

    import lps_pkg::*;

    localparam int IW = $clog2(PALETTE_DEPTH);
    localparam int LW = $clog2(PALETTE_DEPTH + 1);
    localparam int AW = $clog2(2 * PALETTE_DEPTH);
    localparam int CW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    localparam logic REG_CHASE_A_LEN = 1'b0;
    localparam logic REG_CHASE_B_LEN = 1'b1;

    localparam logic [1:0] DIR_RISE = 2'd0;
    localparam logic [1:0] DIR_FALL = 2'd1;
    localparam logic [1:0] DIR_HOLD = 2'd2;

    localparam logic [2:0] HOLD_INIT  = 3'd5;
    localparam logic [3:0] LEVEL_DARK = 4'd9;
    localparam logic [4:0] LEN_INIT   = 5'd16;

    function automatic logic [LW-1:0] eff_len(input logic [4:0] r);
        if (r == '0)
            return LW'(1);
        else if (int'(r) > PALETTE_DEPTH)
            return LW'(PALETTE_DEPTH);
        else
            return LW'(r);
    endfunction

    function automatic logic [IW-1:0] chase_start(input logic [IW-1:0] p,
                                                  input logic [LW-1:0] len);
        if (p == '0 || LW'(p) >= len)
            return '0;
        else
            return IW'(len - LW'(p));
    endfunction

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] n;
        n = LW'(p) + LW'(1);
        if (n >= len)
            return '0;
        else
            return IW'(n);
    endfunction

    // white drive level: 255 / level, black from the dark level up
    function automatic logic [7:0] fade_drive(input logic [3:0] lvl);
        case (lvl)
            4'd0:    return 8'd255;
            4'd1:    return 8'd255;
            4'd2:    return 8'd127;
            4'd3:    return 8'd85;
            4'd4:    return 8'd63;
            4'd5:    return 8'd51;
            4'd6:    return 8'd42;
            4'd7:    return 8'd36;
            4'd8:    return 8'd31;
            default: return 8'd0;
        endcase
    endfunction

    // effect state
    logic [4:0]    len_a_reg, len_b_reg;
    logic [1:0]    mode_reg, mode_next;
    logic [IW-1:0] pos_a_reg, pos_a_next;
    logic [IW-1:0] pos_b_reg, pos_b_next;
    logic [3:0]    level_reg, level_next;
    logic [1:0]    dir_reg, dir_next;
    logic [2:0]    hold_reg, hold_next;

    // beat generator
    logic          gen_busy_reg, gen_busy_next;
    logic          gen_single_reg, gen_single_next;
    logic          gen_pal_reg, gen_pal_next;
    logic          gen_sel_reg, gen_sel_next;
    logic [CW-1:0] gen_led_reg, gen_led_next;
    logic [IW-1:0] gen_c_reg, gen_c_next;
    logic [LW-1:0] gen_len_reg, gen_len_next;
    logic [7:0]    gen_flat_reg, gen_flat_next;

    // ram read stage and output register
    logic          s1_valid_reg, s1_valid_next;
    logic [CW-1:0] s1_led_reg;
    logic          s1_last_reg;
    logic          s1_pal_reg;
    logic [7:0]    s1_flat_reg;
    logic [1:0]    s1_mode_reg;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg;

    logic          issue, gen_last, s1_adv;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_rdata;

    // fade step applied after a fade refresh
    logic [3:0] fade_lvl_upd;
    logic [1:0] fade_dir_upd;
    logic [2:0] fade_hold_upd;

    always_comb
    begin
        fade_lvl_upd  = level_reg;
        fade_dir_upd  = dir_reg;
        fade_hold_upd = hold_reg;
        if (level_reg >= LEVEL_DARK)
        begin
            fade_dir_upd = DIR_FALL;
        end
        else if (level_reg == 4'd1 && dir_reg == DIR_FALL)
        begin
            fade_dir_upd  = DIR_HOLD;
            fade_hold_upd = HOLD_INIT;
        end
        if (fade_dir_upd == DIR_FALL)
        begin
            fade_lvl_upd = level_reg - 4'd1;
        end
        else if (fade_dir_upd == DIR_RISE)
        begin
            fade_lvl_upd = level_reg + 4'd1;
        end
        else if (fade_dir_upd == DIR_HOLD && fade_hold_upd != '0)
        begin
            fade_hold_upd = fade_hold_upd - 3'd1;
        end
        else
        begin
            fade_dir_upd = DIR_RISE;
        end
    end

    assign q_pop    = !gen_busy_reg && !q_empty;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign issue    = gen_busy_reg && (!s1_valid_reg || s1_adv);
    assign gen_last = gen_single_reg || (gen_led_reg == CW'(LED_COUNT - 1));

    assign ram_we    = q_pop && (q_cmd.op == OP_LOAD);
    assign ram_waddr = q_cmd.palette_select ?
                       AW'(PALETTE_DEPTH) + AW'(q_cmd.entry_index) : AW'(q_cmd.entry_index);
    assign ram_raddr = gen_sel_reg ? AW'(PALETTE_DEPTH) + AW'(gen_c_reg) : AW'(gen_c_reg);

    always_comb
    begin
        mode_next       = mode_reg;
        pos_a_next      = pos_a_reg;
        pos_b_next      = pos_b_reg;
        level_next      = level_reg;
        dir_next        = dir_reg;
        hold_next       = hold_reg;
        gen_busy_next   = gen_busy_reg;
        gen_single_next = gen_single_reg;
        gen_pal_next    = gen_pal_reg;
        gen_sel_next    = gen_sel_reg;
        gen_led_next    = gen_led_reg;
        gen_c_next      = gen_c_reg;
        gen_len_next    = gen_len_reg;
        gen_flat_next   = gen_flat_reg;

        if (q_pop)
        begin
            case (q_cmd.op)
                OP_REFRESH:
                begin
                    gen_busy_next   = 1'b1;
                    gen_single_next = 1'b0;
                    gen_led_next    = '0;
                    gen_pal_next    = 1'b0;
                    gen_flat_next   = 8'd0;
                    case (mode_reg)
                        MODE_CHASE_A:
                        begin
                            gen_pal_next = 1'b1;
                            gen_sel_next = 1'b0;
                            gen_len_next = eff_len(len_a_reg);
                            gen_c_next   = chase_start(pos_a_reg, eff_len(len_a_reg));
                            pos_a_next   = wrap_inc(pos_a_reg, eff_len(len_a_reg));
                        end
                        MODE_CHASE_B:
                        begin
                            gen_pal_next = 1'b1;
                            gen_sel_next = 1'b1;
                            gen_len_next = eff_len(len_b_reg);
                            gen_c_next   = chase_start(pos_b_reg, eff_len(len_b_reg));
                            pos_b_next   = wrap_inc(pos_b_reg, eff_len(len_b_reg));
                        end
                        MODE_FADE:
                        begin
                            gen_flat_next = fade_drive(level_reg);
                            level_next    = fade_lvl_upd;
                            dir_next      = fade_dir_upd;
                            hold_next     = fade_hold_upd;
                        end
                        default:
                        begin
                            gen_flat_next = 8'd0;
                        end
                    endcase
                end
                OP_MODE:
                begin
                    gen_busy_next   = 1'b1;
                    gen_single_next = 1'b1;
                    gen_led_next    = '0;
                    gen_pal_next    = 1'b0;
                    gen_flat_next   = 8'd0;
                    case (q_cmd.mode_value)
                        MODE_CHASE_A:
                        begin
                            mode_next  = MODE_CHASE_A;
                            pos_a_next = '0;
                        end
                        MODE_CHASE_B:
                        begin
                            mode_next  = MODE_CHASE_B;
                            pos_b_next = '0;
                        end
                        MODE_FADE:
                        begin
                            mode_next  = MODE_FADE;
                            level_next = 4'd1;
                            dir_next   = DIR_FALL;
                            hold_next  = HOLD_INIT;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                default:
                begin
                    gen_busy_next = 1'b0;
                end
            endcase
        end

        if (issue)
        begin
            gen_led_next = CW'(gen_led_reg + 1'b1);
            gen_c_next   = wrap_inc(gen_c_reg, gen_len_reg);
            if (gen_last)
            begin
                gen_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg      <= LEN_INIT;
            len_b_reg      <= LEN_INIT;
            mode_reg       <= MODE_OFF;
            pos_a_reg      <= '0;
            pos_b_reg      <= '0;
            level_reg      <= 4'd1;
            dir_reg        <= DIR_FALL;
            hold_reg       <= HOLD_INIT;
            gen_busy_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_CHASE_A_LEN)
                len_a_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_CHASE_B_LEN)
                len_b_reg <= cfg_data;
            mode_reg      <= mode_next;
            pos_a_reg     <= pos_a_next;
            pos_b_reg     <= pos_b_next;
            level_reg     <= level_next;
            dir_reg       <= dir_next;
            hold_reg      <= hold_next;
            gen_busy_reg  <= gen_busy_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gen_single_reg <= gen_single_next;
        gen_pal_reg    <= gen_pal_next;
        gen_sel_reg    <= gen_sel_next;
        gen_led_reg    <= gen_led_next;
        gen_c_reg      <= gen_c_next;
        gen_len_reg    <= gen_len_next;
        gen_flat_reg   <= gen_flat_next;
        if (issue)
        begin
            s1_led_reg  <= gen_led_reg;
            s1_last_reg <= gen_last;
            s1_pal_reg  <= gen_pal_reg;
            s1_flat_reg <= gen_flat_reg;
            s1_mode_reg <= mode_reg;
        end
        if (s1_adv)
        begin
            out_data_reg.led_index   <= 5'(s1_led_reg);
            out_data_reg.out_red     <= s1_pal_reg ? ram_rdata[23:16] : s1_flat_reg;
            out_data_reg.out_green   <= s1_pal_reg ? ram_rdata[15:8]  : s1_flat_reg;
            out_data_reg.out_blue    <= s1_pal_reg ? ram_rdata[7:0]   : s1_flat_reg;
            out_data_reg.active_mode <= s1_mode_reg;
            out_data_reg.last        <= s1_last_reg;
        end
    end

    lps_ram #(
        .WIDTH (24),
        .DEPTH (2 * PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_cmd.color),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/led_pattern_sequencer.sv
// top level of the led pattern sequencer
//
// usage: items come in on the in_valid / in_ready channel, one beat per item:
// refresh, set mode or palette load. result beats leave on out_valid /
// out_ready. a refresh gives LED_COUNT beats (led 0 first, last set on the
// final led), a set mode gives one beat carrying the resulting mode (a set
// mode to off leaves the mode as it was), a load gives none. the user writes
// the chase lengths through cfg_we / cfg_index / cfg_data only while the
// block is idle; the block does not enforce this. an item goes through the
// queue, generator, ram read stage and output register. throughput: one led
// color per cycle out of the palette ram read port unless out_ready stalls
// it; the back end takes a new command only when done with the last. a 4
// entry command queue lets the front keep taking beats while the back end is busy.
// reset: mode off, chase positions zero, fade at level 1 falling, lengths 16,
// queue and pipeline empty. palette contents are undefined until loaded.
// stall: when out_ready is low the output register holds its beat, the ram
// stage and generator stop behind it, and in_ready drops once the queue fills.
module led_pattern_sequencer #(
    parameter int LED_COUNT     = lps_pkg::LED_COUNT_DEF,
    parameter int PALETTE_DEPTH = lps_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lps_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lps_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);

    import lps_pkg::*;

    // front to queue
    logic q_push;
    logic q_full;
    cmd_t q_in_cmd;

    // queue to back end
    logic q_pop;
    logic q_empty;
    cmd_t q_out_cmd;

    // front end classifies each beat; kind 3 and out of range loads vanish here
    lps_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    lps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out_cmd),
        .empty (q_empty)
    );

    // back end owns the effect state, the palette ram and the output register
    lps_back #(
        .LED_COUNT     (LED_COUNT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_cmd     (q_out_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/lps_checker.sv
// port level checks for the led pattern sequencer, bound to the top level
module lps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input lps_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input lps_pkg::out_item_t out_data
);

    import lps_pkg::*;

    // a stalled input beat stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // nothing comes out while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat during reset");

    // off mode only ever drives black
    a_off_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.active_mode == MODE_OFF |->
        out_data.out_red == 8'd0 && out_data.out_green == 8'd0 &&
        out_data.out_blue == 8'd0)
        else $error("color driven in off mode");

    // fade mode is pure white scaling
    a_fade_gray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.active_mode == MODE_FADE |->
        out_data.out_red == out_data.out_green &&
        out_data.out_green == out_data.out_blue)
        else $error("fade beat not gray");

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
